@@ rtl/ethernet_media_autosense_fsm_defines.svh @@
// assertion macros for the media autosense block
`ifndef ETHERNET_MEDIA_AUTOSENSE_FSM_DEFINES_SVH
`define ETHERNET_MEDIA_AUTOSENSE_FSM_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define EMAS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define EMAS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/emas_pkg.sv @@
// shared types, codes and constants of the media autosense block
`default_nettype none

package emas_pkg;

  localparam int unsigned STATUS_W   = 10;
  localparam int unsigned PORT_W     = 5;
  localparam int unsigned INDEX_W    = 3;
  localparam int unsigned TICK_W     = 10;
  localparam int unsigned COUNT_W    = 4;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned LEAF_W     = 16;

  localparam logic [COUNT_W-1:0] MAX_LEAVES = 4'd8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CHIP_KIND  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MEDIA_LOCK = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LEAF_COUNT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_LOW  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_HIGH = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FD_MASK    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_START_PORT = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_START_IDX  = 3'd7;

  // chip kinds
  localparam logic [1:0] KIND_21040 = 2'd0;
  localparam logic [1:0] KIND_21041 = 2'd1;
  localparam logic [1:0] KIND_TABLE = 2'd2;

  // leaf types
  localparam logic [2:0] LEAF_SIA     = 3'd0;
  localparam logic [2:0] LEAF_MII     = 3'd1;
  localparam logic [2:0] LEAF_MII_ALT = 3'd3;
  localparam logic [2:0] LEAF_SYM     = 3'd4;

  localparam logic [PORT_W-1:0] MEDIA_NOSENSE_QUIRK = 5'd3;

  // status bit positions
  localparam int unsigned ST_LINK_ERR  = 1;
  localparam int unsigned ST_LINK_FAIL = 2;
  localparam int unsigned ST_AUI_ACT   = 8;
  localparam int unsigned ST_ALT_ACT   = 9;

  // 21040 / 21041 ports
  localparam logic [PORT_W-1:0] PORT_TP      = 5'd0;
  localparam logic [PORT_W-1:0] PORT_BNC     = 5'd1;
  localparam logic [PORT_W-1:0] PORT_AUI     = 5'd2;
  localparam logic [PORT_W-1:0] PORT_TP_AUTO = 5'd3;
  localparam logic [PORT_W-1:0] PORT_TP_FD   = 5'd4;

  // tick intervals in tenths of a second
  localparam logic [TICK_W-1:0] TICK_2S   = 10'd20;
  localparam logic [TICK_W-1:0] TICK_2S4  = 10'd24;
  localparam logic [TICK_W-1:0] TICK_10S  = 10'd100;
  localparam logic [TICK_W-1:0] TICK_20S  = 10'd200;
  localparam logic [TICK_W-1:0] TICK_30S  = 10'd300;
  localparam logic [TICK_W-1:0] TICK_60S  = 10'd600;

  // register reset values
  localparam logic [1:0]         CHIP_KIND_RST   = KIND_TABLE;
  localparam logic [PORT_W-1:0]  START_PORT_RST  = 5'd0;
  localparam logic [INDEX_W-1:0] START_INDEX_RST = 3'd0;

  typedef struct packed {
    logic latch;
    logic eval;
    logic walk_step;
    logic load_out;
  } emas_cmd_t;

  typedef struct packed {
    logic need_walk;
    logic walk_done;
    logic out_free;
  } emas_sts_t;

  function automatic logic [LEAF_W-1:0] leaf_word(input logic [63:0] lo,
                                                  input logic [63:0] hi,
                                                  input logic [INDEX_W-1:0] idx);
    logic [63:0] w;
    w = idx[2] ? hi : lo;
    return w[{idx[1:0], 4'b0000} +: LEAF_W];
  endfunction

endpackage

`default_nettype wire

@@ rtl/emas_if.sv @@
// valid/ready channels for status items and result items
`default_nettype none

interface emas_in_if;
  logic                              valid;
  logic                              ready;
  logic [emas_pkg::STATUS_W-1:0]     sia_status;

  modport source (output valid, output sia_status, input ready);
  modport sink   (input valid, input sia_status, output ready);
endinterface

interface emas_out_if;
  logic                              valid;
  logic                              ready;
  logic [emas_pkg::PORT_W-1:0]       port;
  logic                              select_strobe;
  logic                              restart_strobe;
  logic                              sia_reload;
  logic [emas_pkg::TICK_W-1:0]       next_tick_tenths;
  logic [emas_pkg::INDEX_W-1:0]      leaf_index;

  modport source (output valid, output port, output select_strobe, output restart_strobe,
                  output sia_reload, output next_tick_tenths, output leaf_index,
                  input ready);
  modport sink   (input valid, input port, input select_strobe, input restart_strobe,
                  input sia_reload, input next_tick_tenths, input leaf_index,
                  output ready);
endinterface

`default_nettype wire

@@ rtl/emas_dp.sv @@
// datapath: configuration, media state, port rules, table walk and output register
`default_nettype none
`include "ethernet_media_autosense_fsm_defines.svh"

module emas_dp (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [emas_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [emas_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  wire logic [emas_pkg::STATUS_W-1:0]      sia_status_i,
  input  wire emas_pkg::emas_cmd_t                cmd_i,
  output      emas_pkg::emas_sts_t                sts_o,
  input  wire logic                               out_ready_i,
  output      logic                               out_valid_o,
  output      logic [emas_pkg::PORT_W-1:0]        out_port_o,
  output      logic                               out_select_o,
  output      logic                               out_restart_o,
  output      logic                               out_sia_reload_o,
  output      logic [emas_pkg::TICK_W-1:0]        out_tick_o,
  output      logic [emas_pkg::INDEX_W-1:0]       out_index_o
);

  // configuration
  logic [1:0]                      chip_kind_q;
  logic                            media_lock_q;
  logic [emas_pkg::COUNT_W-1:0]    leaf_count_q;
  logic [63:0]                     table_low_q;
  logic [63:0]                     table_high_q;
  logic [31:0]                     fd_mask_q;

  // media state
  logic [emas_pkg::PORT_W-1:0]     port_q;
  logic [emas_pkg::INDEX_W-1:0]    index_q;
  logic                            sensed_q;
  logic [emas_pkg::STATUS_W-1:0]   st_q;
  logic [emas_pkg::INDEX_W-1:0]    walk_idx_q;
  logic [emas_pkg::COUNT_W-1:0]    tries_q;

  // result of the current item
  logic                            sel_q;
  logic                            rst_q;
  logic                            sia_q;
  logic [emas_pkg::TICK_W-1:0]     tick_q;

  // output register
  logic                            out_valid_q;
  logic [emas_pkg::PORT_W-1:0]     out_port_q;
  logic                            out_sel_q;
  logic                            out_rst_q;
  logic                            out_sia_q;
  logic [emas_pkg::TICK_W-1:0]     out_tick_q;
  logic [emas_pkg::INDEX_W-1:0]    out_index_q;

  logic [emas_pkg::COUNT_W-1:0]    eff_cnt;
  logic [emas_pkg::COUNT_W-1:0]    cnt_m1;

  // rule evaluation
  logic [emas_pkg::LEAF_W-1:0]     ev_leaf;
  logic [emas_pkg::PORT_W-1:0]     ev_port;
  logic                            ev_sensed;
  logic                            ev_sel;
  logic                            ev_sia;
  logic [emas_pkg::TICK_W-1:0]     ev_tick;
  logic                            ev_walk;

  // table walk
  logic [emas_pkg::INDEX_W-1:0]    wk_idx_m1;
  logic                            wk_wrap;
  logic [emas_pkg::INDEX_W-1:0]    wk_next;
  logic [emas_pkg::LEAF_W-1:0]     wk_leaf;
  logic [emas_pkg::PORT_W-1:0]     wk_media;
  logic                            wk_hit;
  logic                            wk_exhausted;

  assign eff_cnt = (leaf_count_q > emas_pkg::MAX_LEAVES) ? emas_pkg::MAX_LEAVES : leaf_count_q;
  assign cnt_m1  = eff_cnt - 4'd1;

  assign ev_leaf = emas_pkg::leaf_word(table_low_q, table_high_q, index_q);

  always_comb begin
    logic [2:0]                  ltype;
    logic [emas_pkg::PORT_W-1:0] lmedia;
    logic [2:0]                  lbit;
    logic                        lactive_low;
    logic                        lnosense;
    logic                        lquirk;
    logic [7:0]                  st_low;

    ltype       = ev_leaf[2:0];
    lmedia      = ev_leaf[7:3];
    lbit        = ev_leaf[10:8];
    lactive_low = ev_leaf[11];
    lnosense    = ev_leaf[12];
    lquirk      = ev_leaf[13];
    st_low      = st_q[7:0];

    ev_port   = port_q;
    ev_sensed = sensed_q;
    ev_sel    = 1'b0;
    ev_sia    = 1'b0;
    ev_tick   = emas_pkg::TICK_2S;
    ev_walk   = 1'b0;

    case (chip_kind_q)
      emas_pkg::KIND_21040: begin
        if (!media_lock_q && st_q[emas_pkg::ST_LINK_ERR]) begin
          ev_port = (port_q == emas_pkg::PORT_AUI) ? emas_pkg::PORT_TP : emas_pkg::PORT_AUI;
          ev_sel  = 1'b1;
        end
      end
      emas_pkg::KIND_21041: begin
        if (!media_lock_q) begin
          if (port_q == emas_pkg::PORT_TP || port_q == emas_pkg::PORT_TP_AUTO ||
              port_q == emas_pkg::PORT_TP_FD) begin
            if (st_q[emas_pkg::ST_LINK_FAIL]) begin
              ev_sensed = 1'b1;
              ev_port   = st_q[emas_pkg::ST_ALT_ACT] ? emas_pkg::PORT_AUI : emas_pkg::PORT_BNC;
              ev_sia    = 1'b1;
              ev_tick   = emas_pkg::TICK_10S;
            end else begin
              ev_tick = emas_pkg::TICK_30S;
            end
          end else if (port_q == emas_pkg::PORT_BNC || port_q == emas_pkg::PORT_AUI) begin
            if (st_q[emas_pkg::ST_AUI_ACT]) begin
              ev_tick   = emas_pkg::TICK_30S;
              ev_sensed = 1'b0;
            end else if (!st_q[emas_pkg::ST_LINK_FAIL]) begin
              ev_port = emas_pkg::PORT_TP;
              ev_sel  = 1'b1;
              ev_tick = emas_pkg::TICK_2S4;
            end else if (sensed_q || st_q[emas_pkg::ST_LINK_ERR]) begin
              ev_port = emas_pkg::PORT_TP_AUTO - port_q;
              ev_sel  = 1'b1;
              ev_tick = emas_pkg::TICK_20S;
            end else begin
              ev_tick = emas_pkg::TICK_20S;
            end
          end
        end
      end
      default: begin
        if (eff_cnt == '0) begin
          ev_tick = emas_pkg::TICK_60S;
        end else if (ltype == emas_pkg::LEAF_SIA || ltype == emas_pkg::LEAF_SYM) begin
          if (lnosense) begin
            if (ltype == emas_pkg::LEAF_SYM && lmedia == emas_pkg::MEDIA_NOSENSE_QUIRK &&
                st_q[emas_pkg::ST_LINK_ERR]) begin
              ev_walk = 1'b1;
            end
          end else if (lactive_low != st_low[lbit]) begin
            if (lquirk) begin
              ev_tick = emas_pkg::TICK_60S;
            end
          end else if (!media_lock_q) begin
            ev_walk = 1'b1;
          end
        end else if (ltype == emas_pkg::LEAF_MII || ltype == emas_pkg::LEAF_MII_ALT) begin
          ev_tick = emas_pkg::TICK_60S;
        end
      end
    endcase
  end

  assign wk_idx_m1    = walk_idx_q - 3'd1;
  assign wk_wrap      = (walk_idx_q == '0) || ({1'b0, wk_idx_m1} >= eff_cnt);
  assign wk_next      = wk_wrap ? cnt_m1[emas_pkg::INDEX_W-1:0] : wk_idx_m1;
  assign wk_leaf      = emas_pkg::leaf_word(table_low_q, table_high_q, wk_next);
  assign wk_media     = wk_leaf[7:3];
  assign wk_hit       = !fd_mask_q[wk_media];
  assign wk_exhausted = (tries_q == eff_cnt);

  assign sts_o.need_walk = ev_walk;
  assign sts_o.walk_done = wk_exhausted || wk_hit;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chip_kind_q   <= emas_pkg::CHIP_KIND_RST;
      media_lock_q  <= 1'b0;
      leaf_count_q  <= '0;
      table_low_q   <= '0;
      table_high_q  <= '0;
      fd_mask_q     <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        emas_pkg::CFG_CHIP_KIND:  chip_kind_q   <= cfg_data_i[1:0];
        emas_pkg::CFG_MEDIA_LOCK: media_lock_q  <= cfg_data_i[0];
        emas_pkg::CFG_LEAF_COUNT: leaf_count_q  <= cfg_data_i[emas_pkg::COUNT_W-1:0];
        emas_pkg::CFG_TABLE_LOW:  table_low_q   <= cfg_data_i;
        emas_pkg::CFG_TABLE_HIGH: table_high_q  <= cfg_data_i;
        emas_pkg::CFG_FD_MASK:    fd_mask_q     <= cfg_data_i[31:0];
        // start values only matter at reset, where they are back at their defaults
        emas_pkg::CFG_START_PORT: ;
        emas_pkg::CFG_START_IDX:  ;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      port_q     <= emas_pkg::START_PORT_RST;
      index_q    <= emas_pkg::START_INDEX_RST;
      sensed_q   <= 1'b0;
      walk_idx_q <= '0;
      tries_q    <= '0;
    end else if (cmd_i.eval) begin
      port_q     <= ev_port;
      sensed_q   <= ev_sensed;
      walk_idx_q <= index_q;
      tries_q    <= '0;
    end else if (cmd_i.walk_step && !wk_exhausted) begin
      if (wk_hit) begin
        port_q  <= wk_media;
        index_q <= wk_next;
      end else begin
        walk_idx_q <= wk_next;
        tries_q    <= tries_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      st_q <= sia_status_i;
    end
    if (cmd_i.eval) begin
      sel_q  <= ev_sel;
      rst_q  <= 1'b0;
      sia_q  <= ev_sia;
      tick_q <= ev_tick;
    end else if (cmd_i.walk_step && !wk_exhausted && wk_hit) begin
      sel_q  <= 1'b1;
      rst_q  <= 1'b1;
      tick_q <= emas_pkg::TICK_2S4;
    end
    if (cmd_i.load_out) begin
      out_port_q  <= port_q;
      out_sel_q   <= sel_q;
      out_rst_q   <= rst_q;
      out_sia_q   <= sia_q;
      out_tick_q  <= tick_q;
      out_index_q <= index_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_port_o       = out_port_q;
  assign out_select_o     = out_sel_q;
  assign out_restart_o    = out_rst_q;
  assign out_sia_reload_o = out_sia_q;
  assign out_tick_o       = out_tick_q;
  assign out_index_o      = out_index_q;

  `EMAS_ASSERT_NOW(a_walk_bounded, cmd_i.walk_step, tries_q <= eff_cnt, "walk ran past leaf count")
  `EMAS_ASSERT_NOW(a_tick_range, out_valid_q, (out_tick_q >= emas_pkg::TICK_2S) && (out_tick_q <= emas_pkg::TICK_60S), "tick interval out of range")
  `EMAS_ASSERT_NOW(a_no_overwrite, cmd_i.load_out, !out_valid_q || out_ready_i, "result overwritten before taken")

endmodule

`default_nettype wire

@@ rtl/emas_ctrl.sv @@
// controller: sequences latch, rule evaluation, table walk and result hand-off
`default_nettype none
`include "ethernet_media_autosense_fsm_defines.svh"

module emas_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output      logic                 in_ready_o,
  input  wire emas_pkg::emas_sts_t  sts_i,
  output      emas_pkg::emas_cmd_t  cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EVAL = 2'd1;
  localparam logic [1:0] S_WALK = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state_q;
  logic [1:0] state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d         = state_q;
    cmd_o.latch     = 1'b0;
    cmd_o.eval      = 1'b0;
    cmd_o.walk_step = 1'b0;
    cmd_o.load_out  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d    = sts_i.need_walk ? S_WALK : S_DONE;
      end
      S_WALK: begin
        cmd_o.walk_step = 1'b1;
        if (sts_i.walk_done) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `EMAS_ASSERT_NEXT(a_accept_evals, in_valid_i && in_ready_o, state_q == S_EVAL, "accepted item not evaluated")
  `EMAS_ASSERT_NEXT(a_walk_ends, (state_q == S_WALK) && sts_i.walk_done, state_q == S_DONE, "walk did not finish")
  `EMAS_ASSERT_NEXT(a_load_frees, cmd_o.load_out, in_ready_o, "not ready after result hand-off")

endmodule

`default_nettype wire

@@ rtl/ethernet_media_autosense_fsm.sv @@
// Media autosense monitor: one status item in, one result item out per tick.
//
// in_ch carries one monitor tick with the serial interface status word. out_ch returns
// the selected port, the select / restart / SIA-reload strobes, the next tick interval
// in tenths of a second and the current media leaf index. The configuration port
// (cfg_we_i, cfg_idx_i, cfg_data_i) writes the rule registers, one per clock.
// The accepted item's status word is latched, the rules are evaluated, the table walk
// runs when the current leaf calls for it, and the result goes to the output register.
// A new item is taken only once the result is loaded; the table walk checks one leaf
// per cycle until it finds a leaf whose media is not masked or has tried them all.
// The result sits in an output register; the next item is accepted while it waits,
// and a stalled receiver holds the following result in the controller until the
// register is free, with in_ch not ready meanwhile.
// Reset clears all configuration to defaults, sets port and leaf index to the
// start values and clears the sensed flag and the output valid.
`default_nettype none

module ethernet_media_autosense_fsm (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  emas_in_if.sink                               in_ch,
  emas_out_if.source                            out_ch,
  input  wire logic                             cfg_we_i,
  input  wire logic [emas_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [emas_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  emas_pkg::emas_cmd_t cmd;
  emas_pkg::emas_sts_t sts;
  logic                in_ready;

  emas_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  emas_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .sia_status_i     (in_ch.sia_status),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .out_ready_i      (out_ch.ready),
    .out_valid_o      (out_ch.valid),
    .out_port_o       (out_ch.port),
    .out_select_o     (out_ch.select_strobe),
    .out_restart_o    (out_ch.restart_strobe),
    .out_sia_reload_o (out_ch.sia_reload),
    .out_tick_o       (out_ch.next_tick_tenths),
    .out_index_o      (out_ch.leaf_index)
  );

  assign in_ch.ready = in_ready;

endmodule

`default_nettype wire
